[rtl/self_organizing_list_count_search_defines.svh]
// assertion macros for the self-organizing list
`ifndef SELF_ORGANIZING_LIST_COUNT_SEARCH_DEFINES_SVH
`define SELF_ORGANIZING_LIST_COUNT_SEARCH_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SOLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SOLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sols_pkg.sv]
package sols_pkg;

	localparam int unsigned ENTRIES = 256;
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned SLOT_W = 8;
	localparam int unsigned POS_W = 8;
	localparam int unsigned KEY_W = 16;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// item kinds
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	// one result item
	typedef struct packed {
		logic found;
		pos_t found_at;
		pos_t moved_to;
		cnt_t hit_count;
	} res_t;

	// result travelling back toward slot 0
	typedef struct packed {
		logic v;
		res_t res;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic load;
		logic [SLOT_W-1:0] slot;
		key_t key;
		key_t skey;
	} cmd_t;

	// link from a cell to the one behind it
	typedef struct packed {
		logic scan;
		key_t key;
		cnt_t cnt;
	} fwd_t;

	// link from a cell to the one in front of it
	typedef struct packed {
		logic bub;
		logic swap;
		pos_t at;
		key_t key;
		cnt_t cnt;
		rsp_t rsp;
	} bwd_t;

endpackage

[rtl/sols_cell.sv]
module sols_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sols_pkg::idx_t  idx,
	input  sols_pkg::cmd_t  cmd,
	input  sols_pkg::fwd_t  fin,
	input  sols_pkg::bwd_t  bin,
	output sols_pkg::fwd_t  fout,
	output sols_pkg::bwd_t  bout
);

	sols_pkg::key_t key_q;
	sols_pkg::cnt_t cnt_q;
	logic           scan_q;
	logic           bub_q;
	sols_pkg::pos_t at_q;
	sols_pkg::rsp_t rsp_q;

	logic           match;
	logic           hit;
	logic           is_first;
	logic           swap;
	logic           stop;
	logic           take;
	logic           load_hit;
	sols_pkg::cnt_t cnt_inc;

	assign match    = (key_q == cmd.skey);
	assign hit      = scan_q && match;
	assign is_first = (idx == '0);
	// move forward only past a strictly smaller count
	assign swap     = bub_q && !is_first && (fin.cnt < cnt_q);
	assign stop     = bub_q && !swap;
	assign take     = bin.bub && bin.swap;
	assign load_hit = cmd.load && (sols_pkg::cmp_t'(cmd.slot) == sols_pkg::cmp_t'(idx));
	assign cnt_inc  = (cnt_q == sols_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	assign fout = '{scan: scan_q && !match, key: key_q, cnt: cnt_q};
	assign bout = '{bub: bub_q, swap: swap, at: at_q, key: key_q, cnt: cnt_q, rsp: rsp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			cnt_q  <= '0;
			scan_q <= 1'b0;
			bub_q  <= 1'b0;
			at_q   <= '0;
			rsp_q  <= '0;
		end else begin
			scan_q <= fin.scan;
			bub_q  <= hit || take;
			if (hit) begin
				at_q <= sols_pkg::pos_t'(idx);
			end else if (take) begin
				at_q <= bin.at;
			end
			if (take) begin
				key_q <= bin.key;
				cnt_q <= bin.cnt;
			end else if (swap) begin
				key_q <= fin.key;
				cnt_q <= fin.cnt;
			end else if (load_hit) begin
				key_q <= cmd.key;
				cnt_q <= '0;
			end else if (hit) begin
				cnt_q <= cnt_inc;
			end
			if (stop) begin
				rsp_q <= '{v: 1'b1, res: '{found: 1'b1, found_at: at_q,
					moved_to: sols_pkg::pos_t'(idx), hit_count: cnt_q}};
			end else begin
				rsp_q <= bin.rsp;
			end
		end
	end

endmodule

[rtl/self_organizing_list_count_search.sv]
// channel  fields                                 direction   transfer when
// in       mode, slot, key                        to block    in_valid && in_ready
// out      found, found_at, moved_to, hit_count   from block  out_valid && out_ready
//
// a load writes its slot and registers its all-zero result at the transfer edge
// a search hitting slot h and settling in slot p registers its result after these steps in order:
// scan and increment up to slot h, swaps from h down to p, stop, shift back to slot 0, output
// a miss registers its all-zero result, and the slowest search is a hit in the last slot
// asynchronous reset clears every key and count at once, no clearing pass
// output register plus one pending entry: input is taken only while idle with nothing pending
`include "self_organizing_list_count_search_defines.svh"

module self_organizing_list_count_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [sols_pkg::SLOT_W-1:0]     slot,
	input  logic [sols_pkg::KEY_W-1:0]      key,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [sols_pkg::POS_W-1:0]      found_at,
	output logic [sols_pkg::POS_W-1:0]      moved_to,
	output logic [sols_pkg::CNT_W-1:0]      hit_count
);

	sols_pkg::state_t state_q;
	sols_pkg::state_t state_d;
	sols_pkg::key_t   skey_q;
	logic             out_v_q;
	sols_pkg::res_t   out_q;
	logic             pend_v_q;
	sols_pkg::res_t   pend_q;

	logic             in_acc;
	logic             start;
	logic             miss;
	sols_pkg::rsp_t   rsp;
	logic             res_ev;
	sols_pkg::res_t   res;
	logic             out_free;
	sols_pkg::cmd_t   cmd;

	// cell row links
	sols_pkg::fwd_t   fin  [sols_pkg::ENTRIES];
	sols_pkg::fwd_t   fout [sols_pkg::ENTRIES];
	sols_pkg::bwd_t   bin  [sols_pkg::ENTRIES];
	sols_pkg::bwd_t   bout [sols_pkg::ENTRIES];

	assign in_ready = (state_q == sols_pkg::ST_IDLE) && !pend_v_q;
	assign in_acc   = in_valid && in_ready;
	// a search drops its scan token into slot 0 at the transfer
	assign start    = in_acc && (mode == sols_pkg::MODE_SEARCH);
	assign cmd      = '{load: in_acc && (mode == sols_pkg::MODE_LOAD),
		slot: slot, key: key, skey: skey_q};

	// scan token falling off the end of the row is a miss
	assign miss = fout[sols_pkg::ENTRIES-1].scan;
	// finished search result arrives here after shifting back to slot 0
	assign rsp  = bout[0].rsp;

	for (genvar g = 0; g < sols_pkg::ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign fin[g] = '{scan: start, key: '0, cnt: '0};
		end else begin : g_fwd
			assign fin[g] = fout[g-1];
		end
		if (g == sols_pkg::ENTRIES - 1) begin : g_tail
			assign bin[g] = '0;
		end else begin : g_bwd
			assign bin[g] = bout[g+1];
		end
		sols_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (sols_pkg::idx_t'(g)),
			.cmd    (cmd),
			.fin    (fin[g]),
			.bin    (bin[g]),
			.fout   (fout[g]),
			.bout   (bout[g])
		);
	end

	// result produced this cycle: load or miss give all zero
	always_comb begin
		res_ev = cmd.load;
		res    = '0;
		if (state_q == sols_pkg::ST_BUSY) begin
			if (rsp.v) begin
				res_ev = 1'b1;
				res    = rsp.res;
			end else if (miss) begin
				res_ev = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sols_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sols_pkg::ST_BUSY;
				end
			end
			sols_pkg::ST_BUSY: begin
				if (rsp.v || miss) begin
					state_d = sols_pkg::ST_IDLE;
				end
			end
			default: state_d = sols_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sols_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			skey_q <= key;
		end
	end

	assign out_free = !out_v_q || out_ready;

	// output register with a one-entry pending stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else begin
				out_v_q <= res_ev;
			end
		end else if (res_ev) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end else if (res_ev) begin
				out_q <= res;
			end
		end else if (res_ev) begin
			pend_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign found     = out_q.found;
	assign found_at  = out_q.found_at;
	assign moved_to  = out_q.moved_to;
	assign hit_count = out_q.hit_count;

	// row events only while a search is under way
	`SOLS_ASSERT_NOW(a_evt_busy, rsp.v || miss, state_q == sols_pkg::ST_BUSY, "row event while idle")
	// one search ends exactly one way
	`SOLS_ASSERT_NOW(a_one_end, state_q == sols_pkg::ST_BUSY, !(rsp.v && miss), "hit and miss together")
	// pending result only sits behind a full output register
	`SOLS_ASSERT_NOW(a_pend_out, pend_v_q, out_v_q, "pending result with empty output")
	// a load yields its result on the next edge
	`SOLS_ASSERT_NEXT(a_load_res, cmd.load, out_v_q || pend_v_q, "load result lost")

endmodule
